### rtl/core/ffr_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package ffr_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int CHUNK_BYTES = 128;
  localparam int FILE_BYTES  = 4096;
  localparam int NAME_BYTES  = 32;

  localparam int FRAME_AW = $clog2(FRAME_BYTES);
  localparam int IDX_W    = FRAME_AW + 1;
  localparam int FILE_AW  = $clog2(FILE_BYTES);
  localparam int SIZE_W   = $clog2(FILE_BYTES + 1);
  localparam int CNT_W    = $clog2(CHUNK_BYTES + 1);
  localparam int OFF_W    = 16 + CNT_W + 1;

  localparam int PADDR_W = 5;

  // Register byte addresses divided by four.
  localparam logic [2:0] REG_HEADER = 3'd0;
  localparam logic [2:0] REG_START  = 3'd1;
  localparam logic [2:0] REG_DATA   = 3'd2;
  localparam logic [2:0] REG_END    = 3'd3;
  localparam logic [2:0] REG_ACK    = 3'd4;
  localparam logic [2:0] REG_NACK   = 3'd5;
  localparam logic [2:0] REG_READY  = 3'd6;

  typedef struct packed {
    logic take;
    logic copy;
    logic clear;
    logic reply_load;
    logic read_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic need_copy;
    logic need_clear;
    logic copy_done;
    logic clear_last;
    logic rep_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/ffr_ctrl.sv
// Controller state machine that sequences requests, copies, clears and replies.
`timescale 1ns / 1ps
`default_nettype none
module ffr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               cmd_i,
  input  wire ffr_pkg::dp_status_t st_i,
  output ffr_pkg::ctrl_cmd_t      cmd_o,
  output logic                    in_stall_o
);

  typedef enum logic [5:0] {
    S_WIPE  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_COPY  = 6'b001000,
    S_CLEAR = 6'b010000,
    S_REPLY = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_WIPE: begin
        cmd_o.clear = 1'b1;
        if (st_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (cmd_i) state_d = S_READ;
          else if (st_i.frame_done) begin
            if (st_i.need_copy) state_d = S_COPY;
            else if (st_i.need_clear) state_d = S_CLEAR;
            else state_d = S_REPLY;
          end
        end
      end
      S_READ: begin
        if (st_i.out_free) begin
          cmd_o.read_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (st_i.copy_done) state_d = S_REPLY;
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clear_last) state_d = S_REPLY;
      end
      S_REPLY: begin
        if (st_i.out_free) begin
          cmd_o.reply_load = 1'b1;
          if (st_i.rep_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_WIPE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ffr_dp.sv
// Datapath: registers, frame parsing, frame and file stores, output register.
`timescale 1ns / 1ps
`default_nettype none
module ffr_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ffr_pkg::ctrl_cmd_t          cmd_i,
  output ffr_pkg::dp_status_t              st_o,
  input  wire logic                        rq_cmd_i,
  input  wire logic [7:0]                  rx_byte_i,
  input  wire logic [ffr_pkg::FILE_AW-1:0] read_addr_i,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ffr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic                             kind_o,
  output logic [7:0]                       out_byte_o,
  output logic                             last_o,
  output logic                             file_saved_o,
  output logic [ffr_pkg::SIZE_W-1:0]       saved_size_o,
  output logic [15:0]                      chunks_received_o
);

  localparam int FAW = ffr_pkg::FRAME_AW;
  localparam int IW  = ffr_pkg::IDX_W;
  localparam int AW  = ffr_pkg::FILE_AW;
  localparam int SW  = ffr_pkg::SIZE_W;
  localparam int CW  = ffr_pkg::CNT_W;
  localparam int OW  = ffr_pkg::OFF_W;

  // Configuration registers.
  logic [7:0] header_q, start_q, data_q, end_q, ack_q, nack_q, ready_q;
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= 8'd170;
      start_q  <= 8'd144;
      data_q   <= 8'd145;
      end_q    <= 8'd146;
      ack_q    <= 8'd1;
      nack_q   <= 8'd2;
      ready_q  <= 8'd3;
    end else if (cfg_wr && (paddr[1:0] == 2'b00)) begin
      unique case (cfg_idx)
        ffr_pkg::REG_HEADER: header_q <= pwdata[7:0];
        ffr_pkg::REG_START:  start_q  <= pwdata[7:0];
        ffr_pkg::REG_DATA:   data_q   <= pwdata[7:0];
        ffr_pkg::REG_END:    end_q    <= pwdata[7:0];
        ffr_pkg::REG_ACK:    ack_q    <= pwdata[7:0];
        ffr_pkg::REG_NACK:   nack_q   <= pwdata[7:0];
        ffr_pkg::REG_READY:  ready_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (cfg_idx)
        ffr_pkg::REG_HEADER: prdata[7:0] = header_q;
        ffr_pkg::REG_START:  prdata[7:0] = start_q;
        ffr_pkg::REG_DATA:   prdata[7:0] = data_q;
        ffr_pkg::REG_END:    prdata[7:0] = end_q;
        ffr_pkg::REG_ACK:    prdata[7:0] = ack_q;
        ffr_pkg::REG_NACK:   prdata[7:0] = nack_q;
        ffr_pkg::REG_READY:  prdata[7:0] = ready_q;
        default: prdata = '0;
      endcase
    end
  end

  // Frame parser state.
  logic [IW-1:0] idx_q;
  logic          in_frame_q, transfer_q;
  logic [SW-1:0] file_len_q;
  logic [15:0]   good_q;
  logic [7:0]    sum_q, cmdb_q, b2_q, b3_q, b4_q;
  logic [31:0]   last4_q;

  logic          line_take, is_hdr, stores, frame_done;
  logic [IW-1:0] idx_nx;
  logic [7:0]    cmd_cur, b2_cur, b4_cur;
  logic          is_start, is_data, is_end, sum_ok;
  logic [9:0]    exp_start, exp_data;
  logic [15:0]   num;
  logic [OW-1:0] offset, span;
  logic          start_bad, data_bad;
  logic          need_copy, need_clear;

  assign line_take = cmd_i.take && !rq_cmd_i;
  assign is_hdr    = (rx_byte_i == header_q);
  assign stores    = !is_hdr && in_frame_q && !idx_q[IW-1];
  assign idx_nx    = idx_q + IW'(1);
  assign cmd_cur   = (idx_q == IW'(1)) ? rx_byte_i : cmdb_q;
  assign b2_cur    = (idx_q == IW'(2)) ? rx_byte_i : b2_q;
  assign b4_cur    = (idx_q == IW'(4)) ? rx_byte_i : b4_q;
  assign is_start  = (cmd_cur == start_q);
  assign is_data   = !is_start && (cmd_cur == data_q);
  assign is_end    = !is_start && !is_data && (cmd_cur == end_q);
  assign exp_start = 10'd8 + 10'(b2_cur);
  assign exp_data  = 10'd6 + 10'(b4_cur);
  assign frame_done = stores && (
      (is_start && (10'(idx_nx) == exp_start)) ||
      (is_data  && (10'(idx_nx) == exp_data)) ||
      (is_end   && (idx_nx == IW'(5))));
  // The checksum byte is the last one, compared with the sum of all before it.
  assign sum_ok = (rx_byte_i == sum_q);

  assign num    = {b2_q, b3_q};
  assign offset = OW'(num - 16'd1) * OW'(ffr_pkg::CHUNK_BYTES);
  assign span   = offset + OW'(b4_q);
  assign start_bad = (b2_q > 8'(ffr_pkg::NAME_BYTES - 1)) ||
                     (last4_q > 32'(ffr_pkg::FILE_BYTES));
  assign data_bad  = !transfer_q || (b4_q > 8'(ffr_pkg::CHUNK_BYTES)) ||
                     (num == 16'd0) || (span > OW'(ffr_pkg::FILE_BYTES));
  assign need_copy  = is_data && !data_bad;
  assign need_clear = (is_start && !start_bad) ||
                      (is_end && transfer_q && sum_ok);

  // Reply captured when the frame completes.
  logic [7:0]    rep_code_q;
  logic          rep_saved_q;
  logic [SW-1:0] rep_size_q;
  logic [15:0]   rep_chunks_q;
  logic [AW-1:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      in_frame_q <= 1'b0;
      transfer_q <= 1'b0;
      file_len_q <= '0;
      good_q     <= '0;
    end else if (line_take) begin
      if (is_hdr) begin
        idx_q      <= IW'(1);
        in_frame_q <= 1'b1;
      end else if (in_frame_q) begin
        if (!stores || frame_done) begin
          idx_q      <= '0;
          in_frame_q <= 1'b0;
        end else begin
          idx_q <= idx_nx;
        end
        if (frame_done) begin
          if (is_start && !start_bad) begin
            file_len_q <= last4_q[SW-1:0];
            good_q     <= '0;
            transfer_q <= sum_ok;
          end else if (is_data && !data_bad && sum_ok) begin
            good_q <= good_q + 16'd1;
          end else if (is_end && transfer_q) begin
            transfer_q <= 1'b0;
            if (sum_ok) begin
              file_len_q <= '0;
              good_q     <= '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_take) begin
      if (is_hdr) begin
        sum_q <= rx_byte_i;
      end else if (stores && !frame_done) begin
        sum_q   <= sum_q + rx_byte_i;
        last4_q <= {last4_q[23:0], rx_byte_i};
        if (idx_q == IW'(1)) cmdb_q <= rx_byte_i;
        if (idx_q == IW'(2)) b2_q <= rx_byte_i;
        if (idx_q == IW'(3)) b3_q <= rx_byte_i;
        if (idx_q == IW'(4)) b4_q <= rx_byte_i;
      end
      if (frame_done) begin
        off_q <= offset[AW-1:0];
        if (is_start && !start_bad) begin
          rep_code_q   <= sum_ok ? ready_q : nack_q;
          rep_saved_q  <= 1'b0;
          rep_size_q   <= '0;
          rep_chunks_q <= '0;
        end else if (is_data && !data_bad && sum_ok) begin
          rep_code_q   <= ack_q;
          rep_saved_q  <= 1'b0;
          rep_size_q   <= '0;
          rep_chunks_q <= good_q + 16'd1;
        end else if (is_end && transfer_q && sum_ok) begin
          rep_code_q   <= ack_q;
          rep_saved_q  <= 1'b1;
          rep_size_q   <= file_len_q;
          rep_chunks_q <= good_q;
        end else begin
          rep_code_q   <= nack_q;
          rep_saved_q  <= 1'b0;
          rep_size_q   <= '0;
          rep_chunks_q <= good_q;
        end
      end
    end
  end

  // Frame store.
  logic [7:0]     frame_mem [ffr_pkg::FRAME_BYTES];
  logic [7:0]     frame_rd_q;
  logic [CW-1:0]  cp_cnt_q;
  logic           cp_wv_q;
  logic [AW-1:0]  cp_waddr_q;
  logic [FAW-1:0] cp_raddr;
  logic           cp_more;

  assign cp_raddr = FAW'(5) + FAW'(cp_cnt_q);
  assign cp_more  = (cp_cnt_q != CW'(b4_q));

  always_ff @(posedge clk_i) begin
    if (line_take && is_hdr) frame_mem[0] <= rx_byte_i;
    else if (line_take && stores) frame_mem[idx_q[FAW-1:0]] <= rx_byte_i;
    if (cmd_i.copy && cp_more) frame_rd_q <= frame_mem[cp_raddr];
  end

  // Copy sequencing: read one payload byte a cycle, write it the next.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_cnt_q <= '0;
      cp_wv_q  <= 1'b0;
    end else if (cmd_i.take) begin
      cp_cnt_q <= '0;
      cp_wv_q  <= 1'b0;
    end else if (cmd_i.copy) begin
      cp_wv_q <= cp_more;
      if (cp_more) cp_cnt_q <= cp_cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy) cp_waddr_q <= off_q + AW'(cp_cnt_q);
  end

  // File store and its clearing pass.
  logic [7:0]    file_mem [ffr_pkg::FILE_BYTES];
  logic [7:0]    file_rd_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_addr_q <= '0;
    else if (cmd_i.clear) clr_addr_q <= clr_addr_q + AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) file_mem[clr_addr_q] <= 8'd0;
    else if (cp_wv_q) file_mem[cp_waddr_q] <= frame_rd_q;
    if (cmd_i.take) file_rd_q <= file_mem[read_addr_i];
  end

  // Reply byte counter and output register.
  logic [1:0] rep_idx_q;
  logic       out_valid_q;
  logic [7:0] rep_byte;

  always_comb begin
    unique case (rep_idx_q)
      2'd0:    rep_byte = header_q;
      2'd1:    rep_byte = rep_code_q;
      default: rep_byte = header_q + rep_code_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.reply_load) rep_idx_q <= (rep_idx_q == 2'd2) ? 2'd0 : rep_idx_q + 2'd1;
      if (cmd_i.reply_load || cmd_i.read_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply_load) begin
      kind_o            <= 1'b0;
      out_byte_o        <= rep_byte;
      last_o            <= (rep_idx_q == 2'd2);
      file_saved_o      <= rep_saved_q;
      saved_size_o      <= rep_size_q;
      chunks_received_o <= rep_chunks_q;
    end else if (cmd_i.read_load) begin
      kind_o            <= 1'b1;
      out_byte_o        <= file_rd_q;
      last_o            <= 1'b1;
      file_saved_o      <= 1'b0;
      saved_size_o      <= '0;
      chunks_received_o <= good_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign st_o.frame_done = frame_done && !rq_cmd_i;
  assign st_o.need_copy  = need_copy;
  assign st_o.need_clear = need_clear;
  assign st_o.copy_done  = !cp_more && !cp_wv_q;
  assign st_o.clear_last = &clr_addr_q;
  assign st_o.rep_last   = (rep_idx_q == 2'd2);
  assign st_o.out_free   = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

### rtl/core/framed_file_receiver_unit.sv
// Top level of the framed file receiver: controller plus datapath.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   cmd_i, rx_byte_i, read_addr_i
//   out      output     out_valid_o / out_stall_i kind_o, out_byte_o, last_o,
//                                                 file_saved_o, saved_size_o,
//                                                 chunks_received_o
//   cfg      input      APB write/read            paddr, pwdata, prdata
//
// A line byte that does not finish a frame is taken without a stall. A read
// request stalls the input until its result enters the output register, which
// waits out any output stall. A finished frame holds the input for its reply
// (three output bytes), and before it for a payload copy of a data frame or a
// file store clearing pass. After reset the file store is cleared before the
// first request is taken. Output stalls hold the reply in the output register.
`timescale 1ns / 1ps
`default_nettype none
module framed_file_receiver_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        cmd_i,
  input  wire logic [7:0]                  rx_byte_i,
  input  wire logic [ffr_pkg::FILE_AW-1:0] read_addr_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             kind_o,
  output logic [7:0]                       out_byte_o,
  output logic                             last_o,
  output logic                             file_saved_o,
  output logic [ffr_pkg::SIZE_W-1:0]       saved_size_o,
  output logic [15:0]                      chunks_received_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ffr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  ffr_pkg::ctrl_cmd_t  cmd;
  ffr_pkg::dp_status_t st;

  assign pready = 1'b1;

  ffr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .st_i       (st),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ffr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .rq_cmd_i          (cmd_i),
    .rx_byte_i         (rx_byte_i),
    .read_addr_i       (read_addr_i),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .out_byte_o        (out_byte_o),
    .last_o            (last_o),
    .file_saved_o      (file_saved_o),
    .saved_size_o      (saved_size_o),
    .chunks_received_o (chunks_received_o)
  );

endmodule
`default_nettype wire

### rtl/core/ffr_checker.sv
// Port-level checker for the framed file receiver and its bind.
`timescale 1ns / 1ps
`default_nettype none
module ffr_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        kind_o,
  input wire logic [7:0]                  out_byte_o,
  input wire logic                        last_o,
  input wire logic                        file_saved_o,
  input wire logic [ffr_pkg::SIZE_W-1:0]  saved_size_o
);

  // A stalled result keeps its bytes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled result changed");

  // A read request always yields a single, final result.
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o)
    else $error("read result not marked last");

  // Only reply bytes can report a saved file.
  a_saved_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && file_saved_o |-> !kind_o)
    else $error("saved flag on read data");

  // A size is only reported with a saved file.
  a_size_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !file_saved_o |-> saved_size_o == '0)
    else $error("size without saved file");

endmodule

bind framed_file_receiver_unit ffr_checker u_ffr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .out_byte_o   (out_byte_o),
  .last_o       (last_o),
  .file_saved_o (file_saved_o),
  .saved_size_o (saved_size_o)
);
`default_nettype wire
